>>> sv/spq_pkg.sv
// shared types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

    // request modes
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam int NODE_W = 8;
    localparam int COST_W = 16;
    localparam int KEY_W  = 16;
    localparam int OCC_W  = 5;

    // one stored queue entry
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [COST_W-1:0] cost;
        logic [KEY_W-1:0]  key;
    } t_entry;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry new_entry;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> sv/spq_cell.sv
// one slot of the sorted shift-register queue
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire logic       i_occupied,
    input  wire logic       i_prev_less,
    input  wire t_entry     i_prev_entry,
    input  wire t_entry     i_next_entry,
    output t_entry          o_entry,
    output logic            o_less
);

    t_entry r_entry;
    t_entry n_entry;

    // stored key strictly below the incoming key: this slot stays put on enqueue
    assign o_less = i_occupied && (r_entry.key < i_ctrl.new_entry.key);

    // keep, take the new entry, shift down from the previous slot, or shift up
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq) begin
            if (o_less) begin
                n_entry = r_entry;
            end else if (i_prev_less) begin
                n_entry = i_ctrl.new_entry;
            end else begin
                n_entry = i_prev_entry;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue_unit.sv
// Sorted min-priority queue built as a chain of compare-and-shift cells.
// Input channel (i_in_valid / o_in_ready) carries one request: i_mode selects
// enqueue of (node, cost, key) or dequeue of the lowest-key entry. Entries
// are held in ascending key order; a new entry goes ahead of equal keys.
// Output channel (o_out_valid / i_out_ready) returns exactly one result per
// request: the dequeued entry with o_item_valid, or o_empty_error, or
// o_overflow when an enqueue met a full queue, plus the new occupancy.
// Every cell compares its key with the incoming key in parallel, so a request
// is applied in the cycle it is accepted and its result is shown the next
// cycle; throughput 1 request per cycle while the receiver does not stall.
// The result sits in an output register; a new request is taken while that
// register is empty or being drained in the same cycle. While the receiver
// stalls, o_in_ready drops and the queue contents hold.
// Synchronous active-low reset empties the queue and the output register;
// slot contents are not cleared, only the count.
`default_nettype none

module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_mode,
    input  wire logic [NODE_W-1:0] i_node_id,
    input  wire logic [COST_W-1:0] i_cost_so_far,
    input  wire logic [KEY_W-1:0]  i_priority_key,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_item_valid,
    output logic [NODE_W-1:0]      o_out_node,
    output logic [COST_W-1:0]      o_out_cost,
    output logic [KEY_W-1:0]       o_out_key,
    output logic                   o_empty_error,
    output logic                   o_overflow,
    output logic [OCC_W-1:0]       o_occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic          r_out_valid;
    logic          r_item_valid;
    t_entry        r_out_entry;
    logic          r_empty_error;
    logic          r_overflow;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    t_cell_ctrl            w_ctrl;
    t_entry                w_entry [CAPACITY];
    logic [CAPACITY-1:0]   w_less;
    logic [CW+OCC_W-1:0]   w_count_ext;

    // request handshake, output register frees when drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);

    // broadcast control to the cells
    always_comb begin
        w_ctrl.enq            = w_accept && (i_mode == MODE_ENQ) && !w_full;
        w_ctrl.deq            = w_accept && (i_mode == MODE_DEQ) && !w_empty;
        w_ctrl.new_entry.node = i_node_id;
        w_ctrl.new_entry.cost = i_cost_so_far;
        w_ctrl.new_entry.key  = i_priority_key;
    end

    // chain of cells, slot 0 holds the lowest key
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   w_prev_less;
        t_entry w_prev_entry;
        t_entry w_next_entry;

        if (g == 0) begin : g_head
            assign w_prev_less  = 1'b1;
            assign w_prev_entry = w_ctrl.new_entry;
        end else begin : g_body
            assign w_prev_less  = w_less[g-1];
            assign w_prev_entry = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_entry = w_entry[g];
        end else begin : g_mid
            assign w_next_entry = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occupied   (CW'(g) < r_count),
            .i_prev_less  (w_prev_less),
            .i_prev_entry (w_prev_entry),
            .i_next_entry (w_next_entry),
            .o_entry      (w_entry[g]),
            .o_less       (w_less[g])
        );
    end

    // occupancy update
    always_comb begin
        n_count = r_count;
        if (w_ctrl.enq) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.deq) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item_valid  <= w_ctrl.deq;
            r_out_entry   <= w_ctrl.deq ? w_entry[0] : '0;
            r_empty_error <= (i_mode == MODE_DEQ) && w_empty;
            r_overflow    <= (i_mode == MODE_ENQ) && w_full;
        end
    end

    // occupancy shown with the result, low bits of the count
    assign w_count_ext = {{OCC_W{1'b0}}, r_count};

    assign o_out_valid   = r_out_valid;
    assign o_item_valid  = r_item_valid;
    assign o_out_node    = r_out_entry.node;
    assign o_out_cost    = r_out_entry.cost;
    assign o_out_key     = r_out_entry.key;
    assign o_empty_error = r_empty_error;
    assign o_overflow    = r_overflow;
    assign o_occupancy   = w_count_ext[OCC_W-1:0];

endmodule

`default_nettype wire

>>> sv/spq_chk.sv
// port-level checks for the sorted priority queue, bound to the top level
`default_nettype none

module spq_chk
    import spq_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic              o_item_valid,
    input wire logic [NODE_W-1:0] o_out_node,
    input wire logic [COST_W-1:0] o_out_cost,
    input wire logic [KEY_W-1:0]  o_out_key,
    input wire logic              o_empty_error,
    input wire logic              o_overflow,
    input wire logic [OCC_W-1:0]  o_occupancy
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_item_valid)
            && $stable(o_out_key) && $stable(o_occupancy))
        else $error("stalled result changed");

    // at most one status flag per result
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_item_valid, o_empty_error, o_overflow}))
        else $error("conflicting result flags");

    // no entry returned means zero payload
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_item_valid |->
            o_out_node == '0 && o_out_cost == '0 && o_out_key == '0)
        else $error("payload not zero without an entry");

    // empty dequeue leaves an empty queue
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_error |-> o_occupancy == '0)
        else $error("empty error with nonzero occupancy");

endmodule

bind sorted_priority_queue_unit spq_chk u_spq_chk (.*);

`default_nettype wire
